@@ design/ddpu_pkg.sv @@
// ----------------------------------------------------------------------------
// ddpu_pkg
// Shared types, register indexes and constants of the phase unwrapper.
// ----------------------------------------------------------------------------
package ddpu_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 12;
    localparam int LEVEL_W = 12;
    localparam int SCALE_W = 3;
    localparam int PHASE_W = 16;
    localparam int DAC_W = 12;
    localparam int ZONE_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SCALE_SELECT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_LEVEL = 3'd3;

    localparam logic [SCALE_W-1:0] RST_SCALE = 3'd0;
    localparam logic [LEVEL_W-1:0] RST_UPPER = 12'd2000;
    localparam logic [LEVEL_W-1:0] RST_LOWER = 12'd550;
    localparam logic [LEVEL_W-1:0] RST_CENTER = 12'd1229;

    localparam logic [SCALE_W-1:0] SCALE_MAX = 3'd5;

    // Slope gain and the divide-by-five reciprocal (exact below 2^22).
    localparam int GAIN = 67;
    localparam int GAIN_W = 7;
    localparam int RECIP_W = 20;
    localparam logic [RECIP_W-1:0] RECIP5 = 20'd838861;
    localparam int RECIP_SHIFT = 22;

    localparam logic [PHASE_W-1:0] ZONE_STEP = 16'd4096;
    localparam logic [PHASE_W-1:0] FULL_TURN = 16'd16384;

    typedef struct packed {
        logic [SCALE_W-1:0] scale_select;
        logic [LEVEL_W-1:0] upper_threshold;
        logic [LEVEL_W-1:0] lower_threshold;
        logic [LEVEL_W-1:0] center_level;
    } cfg_t;

    function automatic logic [SCALE_W-1:0] eff_scale(input logic [SCALE_W-1:0] sel);
        eff_scale = (sel > SCALE_MAX) ? SCALE_MAX : sel;
    endfunction

endpackage

@@ design/ddpu_quotient.sv @@
// ----------------------------------------------------------------------------
// ddpu_quotient
// Sample register and two-stage slope scaling of one detector:
// (sample - center) * 67 / (20 << scale), truncated toward zero, kept mod 2^16.
// ----------------------------------------------------------------------------
module ddpu_quotient #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                          clk,
    input  logic                          load0,
    input  logic                          load1,
    input  logic                          load2,
    input  logic [SAMPLE_BITS-1:0]        sample_in,
    input  ddpu_pkg::cfg_t                cfg,
    output logic [SAMPLE_BITS-1:0]        sample_out,
    output logic [ddpu_pkg::PHASE_W-1:0]  quot
);
    import ddpu_pkg::*;

    localparam int ABS_W = (SAMPLE_BITS > LEVEL_W) ? SAMPLE_BITS : LEVEL_W;
    localparam int P_W = ABS_W + GAIN_W;
    localparam int X_W = P_W - 2;
    localparam int M_W = X_W + RECIP_W;
    localparam int Q_W = M_W - RECIP_SHIFT;

    logic [SAMPLE_BITS-1:0] samp0_reg;
    logic [SAMPLE_BITS-1:0] samp1_reg;
    logic [SAMPLE_BITS-1:0] samp2_reg;
    logic [P_W-1:0]         prod_reg;
    logic                   neg1_reg;
    logic [PHASE_W-1:0]     quot_reg;

    logic signed [ABS_W:0]  diff;
    logic [ABS_W-1:0]       abs_diff;
    logic [P_W-1:0]         prod_next;
    logic [SCALE_W-1:0]     scale;
    logic [X_W-1:0]         x_val;
    logic [M_W-1:0]         mul_val;
    logic [Q_W-1:0]         quo;
    logic [31:0]            quo_ext;
    logic [PHASE_W-1:0]     quot_next;

    always_comb
    begin
        diff = $signed({1'b0, (ABS_W)'(samp0_reg)}) - $signed({1'b0, (ABS_W)'(cfg.center_level)});
        abs_diff = diff[ABS_W] ? (ABS_W)'(-diff) : diff[ABS_W-1:0];
        prod_next = (P_W)'(abs_diff) * (P_W)'(GAIN);
    end

    // Divide by 20 << scale as a shift by scale + 2 followed by a divide by five.
    always_comb
    begin
        scale = eff_scale(cfg.scale_select);
        x_val = (X_W)'((prod_reg >> scale) >> 2);
        mul_val = (M_W)'(x_val) * (M_W)'(RECIP5);
        quo = mul_val[M_W-1:RECIP_SHIFT];
        quo_ext = 32'(quo);
        quot_next = neg1_reg ? (PHASE_W)'(-quo_ext) : quo_ext[PHASE_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (load0)
        begin
            samp0_reg <= sample_in;
        end
        if (load1)
        begin
            samp1_reg <= samp0_reg;
            prod_reg <= prod_next;
            neg1_reg <= diff[ABS_W];
        end
        if (load2)
        begin
            samp2_reg <= samp1_reg;
            quot_reg <= quot_next;
        end
    end

    assign sample_out = samp2_reg;
    assign quot = quot_reg;

endmodule

@@ design/ddpu_tracker.sv @@
// ----------------------------------------------------------------------------
// ddpu_tracker
// Zone tracking, phase reference and output accumulator, with the result
// register.
// ----------------------------------------------------------------------------
module ddpu_tracker #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          upd,
    input  logic [SAMPLE_BITS-1:0]        sample_a,
    input  logic [SAMPLE_BITS-1:0]        sample_b,
    input  logic [ddpu_pkg::PHASE_W-1:0]  quot_a,
    input  logic [ddpu_pkg::PHASE_W-1:0]  quot_b,
    input  ddpu_pkg::cfg_t                cfg,
    output logic [ddpu_pkg::DAC_W-1:0]    dac_code,
    output logic [ddpu_pkg::ZONE_W-1:0]   zone_now,
    output logic [ddpu_pkg::PHASE_W-1:0]  phase_now
);
    import ddpu_pkg::*;

    localparam int CMP_W = (SAMPLE_BITS > LEVEL_W) ? SAMPLE_BITS : LEVEL_W;

    logic               started_reg;
    logic [ZONE_W-1:0]  zone_reg;
    logic [PHASE_W-1:0] ref_reg;
    logic [PHASE_W-1:0] acc_reg;
    logic [DAC_W-1:0]   dac_reg;
    logic [PHASE_W-1:0] phase_reg;

    logic [ZONE_W-1:0]  zone_next;
    logic [PHASE_W-1:0] ref_next;
    logic [PHASE_W-1:0] acc_next;
    logic [PHASE_W-1:0] phase_next;

    logic [SCALE_W-1:0] scale;
    logic [PHASE_W-1:0] step;
    logic [PHASE_W-1:0] full;
    logic [CMP_W-1:0]   a_ext;
    logic [CMP_W-1:0]   b_ext;
    logic [CMP_W-1:0]   x_ext;
    logic [CMP_W-1:0]   upper_ext;
    logic [CMP_W-1:0]   lower_ext;
    logic               go_up;
    logic               go_down;
    logic [PHASE_W-1:0] ref_adj;
    logic [PHASE_W-1:0] q_sel;
    logic [PHASE_W-1:0] zone_base;
    logic signed [PHASE_W+1:0] sum;

    always_comb
    begin
        scale = eff_scale(cfg.scale_select);
        step = ZONE_STEP >> scale;
        full = FULL_TURN >> scale;
        a_ext = (CMP_W)'(sample_a);
        b_ext = (CMP_W)'(sample_b);
        upper_ext = (CMP_W)'(cfg.upper_threshold);
        lower_ext = (CMP_W)'(cfg.lower_threshold);
        x_ext = zone_reg[0] ? b_ext : a_ext;
        go_up = 1'b0;
        go_down = 1'b0;
        ref_adj = ref_reg;
        zone_next = zone_reg;

        if (!started_reg)
        begin
            // Initial zone from which detector leads and where detector_b sits.
            if (a_ext > b_ext)
            begin
                zone_next = (b_ext < lower_ext) ? 2'd0 : 2'd1;
            end
            else
            begin
                zone_next = (b_ext > upper_ext) ? 2'd2 : 2'd3;
            end
        end
        else
        begin
            // Rising slope in zones 0 and 1, falling in zones 2 and 3.
            if (x_ext > upper_ext)
            begin
                go_up = !zone_reg[1];
                go_down = zone_reg[1];
            end
            else if (x_ext < lower_ext)
            begin
                go_up = zone_reg[1];
                go_down = !zone_reg[1];
            end
            if (go_up)
            begin
                zone_next = zone_reg + 2'd1;
                if (zone_reg == 2'd3)
                begin
                    ref_adj = ref_reg - full;
                end
            end
            else if (go_down)
            begin
                zone_next = zone_reg - 2'd1;
                if (zone_reg == 2'd0)
                begin
                    ref_adj = ref_reg + full;
                end
            end
        end

        q_sel = zone_next[0] ? quot_b : quot_a;
        zone_base = (PHASE_W)'(zone_next) * step;
        phase_next = zone_next[1] ? (zone_base - q_sel) : (zone_base + q_sel);

        sum = $signed({2'b00, acc_reg}) + $signed({{2{phase_next[PHASE_W-1]}}, phase_next})
            - $signed({{2{ref_adj[PHASE_W-1]}}, ref_adj});
        acc_next = acc_reg;
        if (started_reg && !sum[PHASE_W+1] && (sum != '0))
        begin
            acc_next = sum[PHASE_W-1:0];
        end
        ref_next = phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
            zone_reg <= '0;
            ref_reg <= '0;
            acc_reg <= '0;
        end
        else if (upd)
        begin
            started_reg <= 1'b1;
            zone_reg <= zone_next;
            ref_reg <= ref_next;
            acc_reg <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd)
        begin
            dac_reg <= acc_next[PHASE_W-1:PHASE_W-DAC_W];
            phase_reg <= phase_next;
        end
    end

    assign dac_code = dac_reg;
    assign zone_now = zone_reg;
    assign phase_now = phase_reg;

`ifndef NO_ASSERTIONS
    a_started_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        started_reg |=> started_reg)
        else $error("started flag dropped");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !upd |=> $stable(zone_reg) && $stable(acc_reg) && $stable(ref_reg))
        else $error("tracker state moved without an update");

    a_ref_follows: assert property (@(posedge clk) disable iff (!rst_n)
        upd |=> ref_reg == phase_reg)
        else $error("phase reference differs from reported phase");

    a_first_keeps_acc: assert property (@(posedge clk) disable iff (!rst_n)
        upd && !started_reg |=> $stable(acc_reg))
        else $error("accumulator changed on the first pair");
`endif

endmodule

@@ design/dual_detector_phase_unwrapper_unit.sv @@
// ----------------------------------------------------------------------------
// dual_detector_phase_unwrapper_unit
// Unwraps the phase of a dual phase-detector front end into a DAC code.
// ----------------------------------------------------------------------------
// Each transaction on the input stream carries one simultaneous sample pair.
// A working zone 0..3 picks the active detector (detector_a in zones 0 and 2,
// detector_b in zones 1 and 3) and the slope sign; the first pair after reset
// sets the zone and phase reference, later pairs step the zone on threshold
// crossings and add the phase change to a 16-bit accumulator, which is kept
// when the sum would be zero or negative. One result transaction leaves for
// every input transaction. The block takes one pair per clock cycle unless a
// stalled output has filled the four register stages (sample, gain product,
// reciprocal divide, tracker/result). The configuration port is always
// ready; write it only while the pipeline is empty.
// ----------------------------------------------------------------------------
module dual_detector_phase_unwrapper_unit #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // tdata: detector_a, detector_b (lowest bits first), zero padded
    input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // tdata: dac_code[11:0], zone_now[13:12], phase_now[29:14], zero padded
    output logic [31:0]                            m_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [ddpu_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [ddpu_pkg::CFG_DATA_W-1:0]        cfg_data
);
    import ddpu_pkg::*;

    localparam int PAD_W = 32 - DAC_W - ZONE_W - PHASE_W;

    cfg_t cfg_reg;

    // Stage valids: sample, product, quotient, result.
    logic v0_reg;
    logic v1_reg;
    logic v2_reg;
    logic vo_reg;
    logic rd0;
    logic rd1;
    logic rd2;
    logic rdo;

    logic [SAMPLE_BITS-1:0] samp_a;
    logic [SAMPLE_BITS-1:0] samp_b;
    logic [PHASE_W-1:0]     quot_a;
    logic [PHASE_W-1:0]     quot_b;
    logic [DAC_W-1:0]       dac_code;
    logic [ZONE_W-1:0]      zone_now;
    logic [PHASE_W-1:0]     phase_now;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scale_select <= RST_SCALE;
            cfg_reg.upper_threshold <= RST_UPPER;
            cfg_reg.lower_threshold <= RST_LOWER;
            cfg_reg.center_level <= RST_CENTER;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_SCALE_SELECT:    cfg_reg.scale_select <= cfg_data[SCALE_W-1:0];
                REG_UPPER_THRESHOLD: cfg_reg.upper_threshold <= cfg_data;
                REG_LOWER_THRESHOLD: cfg_reg.lower_threshold <= cfg_data;
                REG_CENTER_LEVEL:    cfg_reg.center_level <= cfg_data;
                default:             ;
            endcase
        end
    end

    // A stage advances when it is empty or the next stage advances; bubbles
    // collapse so the input keeps flowing while a result waits.
    always_comb
    begin
        rdo = !vo_reg || m_axis_tready;
        rd2 = !v2_reg || rdo;
        rd1 = !v1_reg || rd2;
        rd0 = !v0_reg || rd1;
    end

    assign s_axis_tready = rd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (rd0)
            begin
                v0_reg <= s_axis_tvalid;
            end
            if (rd1)
            begin
                v1_reg <= v0_reg;
            end
            if (rd2)
            begin
                v2_reg <= v1_reg;
            end
            if (rdo)
            begin
                vo_reg <= v2_reg;
            end
        end
    end

    ddpu_quotient #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_quot_a (
        .clk        (clk),
        .load0      (rd0),
        .load1      (rd1),
        .load2      (rd2),
        .sample_in  (s_axis_tdata[SAMPLE_BITS-1:0]),
        .cfg        (cfg_reg),
        .sample_out (samp_a),
        .quot       (quot_a)
    );

    ddpu_quotient #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_quot_b (
        .clk        (clk),
        .load0      (rd0),
        .load1      (rd1),
        .load2      (rd2),
        .sample_in  (s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
        .cfg        (cfg_reg),
        .sample_out (samp_b),
        .quot       (quot_b)
    );

    // Advance the tracker state only when a real pair moves into the result.
    ddpu_tracker #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .upd       (v2_reg && rdo),
        .sample_a  (samp_a),
        .sample_b  (samp_b),
        .quot_a    (quot_a),
        .quot_b    (quot_b),
        .cfg       (cfg_reg),
        .dac_code  (dac_code),
        .zone_now  (zone_now),
        .phase_now (phase_now)
    );

    assign m_axis_tvalid = vo_reg;
    assign m_axis_tdata = {{PAD_W{1'b0}}, phase_now, zone_now, dac_code};

`ifndef NO_ASSERTIONS
    a_empty_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !vo_reg |-> s_axis_tready)
        else $error("input stalled with an empty result stage");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg && !rdo |=> v2_reg && vo_reg)
        else $error("quotient stage lost a transaction under stall");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        v0_reg && v1_reg && v2_reg && vo_reg && !m_axis_tready |-> !s_axis_tready)
        else $error("input accepted into a full pipeline");
`endif

endmodule

@@ tb/sv/tb_dual_detector_phase_unwrapper_unit.sv @@
// ----------------------------------------------------------------------------
// tb_dual_detector_phase_unwrapper_unit
// Self-checking testbench for the dual-detector phase unwrapper.
// ----------------------------------------------------------------------------
// Sample pairs enter on the input stream, and an in-bench tracker updates its
// own zone, phase reference and accumulator for every accepted pair. It
// queues the result the block should return. A receiver process accepts
// each result transaction and compares dac_code, zone_now and phase_now with
// the oldest queued entry. Stimulus runs from a few directed pairs (first
// pair, field extremes, zone wrap both ways) through every scale code,
// threshold and center extremes, and random settings. Most random pairs are
// zone steps forward, back or held, with random content; the rest are
// unconstrained noise. Both stream sides idle at random, and one phase holds
// the output for a long stretch so that the block fills up.
// ----------------------------------------------------------------------------
module tb_dual_detector_phase_unwrapper_unit;

    import ddpu_pkg::*;

    localparam int PIPE_LATENCY = 3;
    localparam int STALL_LIMIT = 2000;
    localparam int DIV_BASE = 20;
    localparam int LEVEL_MAX = 4095;

    typedef struct packed {
        logic [DAC_W-1:0] dac_code;
        logic [ZONE_W-1:0] zone_now;
        logic [PHASE_W-1:0] phase_now;
    } unwrap_result_t;

    typedef enum int {LVL_HIGH, LVL_LOW, LVL_MID} level_kind_t;
    typedef enum int {STEP_FWD, STEP_BACK, STEP_HOLD, STEP_NOISE} step_kind_t;

    logic clk = 1'b0;
    logic rst_n;
    logic [23:0] s_axis_tdata;      // detector_a[11:0], detector_b[23:12]
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [31:0] m_axis_tdata;      // dac_code[11:0], zone_now[13:12], phase_now[29:14]
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    dual_detector_phase_unwrapper_unit #(
        .SAMPLE_BITS(12)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Shadow copy of the configuration registers.
    logic [SCALE_W-1:0] cf_scale = RST_SCALE;
    logic [LEVEL_W-1:0] cf_upper = RST_UPPER;
    logic [LEVEL_W-1:0] cf_lower = RST_LOWER;
    logic [LEVEL_W-1:0] cf_center = RST_CENTER;

    // Tracker state, mirroring the block after reset.
    logic trk_started = 1'b0;
    logic [ZONE_W-1:0] trk_zone = '0;
    logic [PHASE_W-1:0] trk_ref = '0;
    logic [PHASE_W-1:0] trk_accum = '0;

    unwrap_result_t pending_results[$];

    int tx_max_gap = 8;
    int rx_max_stall = 8;
    int rx_hold_cycles = 0;
    int pairs_sent = 0;
    int results_checked = 0;
    int reg_writes = 0;
    int settings_used = 0;
    int mismatch_count = 0;
    int quiet_cycles = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Tracker: phase of a zone, then one update per accepted pair
    // ------------------------------------------------------------------------
    function automatic logic [PHASE_W-1:0] zone_phase_of(input logic [ZONE_W-1:0] zone,
                                                         input logic [LEVEL_W-1:0] level);
        int sc;
        int step;
        int divisor;
        int delta;
        int quot;
        sc = (cf_scale > SCALE_MAX) ? int'(SCALE_MAX) : int'(cf_scale);
        step = int'(ZONE_STEP) >> sc;
        divisor = DIV_BASE << sc;
        delta = int'(level) - int'(cf_center);
        // Falling slope in the upper two zones
        if (zone >= 2)
            delta = -delta;
        // SystemVerilog int division truncates toward zero
        quot = (delta * GAIN) / divisor;
        return PHASE_W'(int'(zone) * step + quot);
    endfunction

    function automatic void unwrap_predict(input logic [LEVEL_W-1:0] det_a,
                                           input logic [LEVEL_W-1:0] det_b);
        logic [LEVEL_W-1:0] act;
        logic [PHASE_W-1:0] ph;
        logic signed [PHASE_W-1:0] ph_s;
        logic signed [PHASE_W-1:0] ref_s;
        int sc;
        int full;
        int z;
        int sgn;
        int sum;
        unwrap_result_t res;
        if (!trk_started)
        begin
            // First pair picks the zone from the ordering of the two detectors
            if (det_a > det_b)
                trk_zone = (det_b < cf_lower) ? 2'd0 : 2'd1;
            else
                trk_zone = (det_b > cf_upper) ? 2'd2 : 2'd3;
            ph = zone_phase_of(trk_zone, trk_zone[0] ? det_b : det_a);
            trk_ref = ph;
            trk_started = 1'b1;
        end
        else
        begin
            sc = (cf_scale > SCALE_MAX) ? int'(SCALE_MAX) : int'(cf_scale);
            full = int'(FULL_TURN) >> sc;
            z = int'(trk_zone);
            sgn = (trk_zone < 2) ? 1 : -1;
            act = trk_zone[0] ? det_b : det_a;
            if (act > cf_upper || act < cf_lower)
            begin
                z += (act > cf_upper) ? sgn : -sgn;
                // Wrap the zone and shift the reference by one full turn
                if (z > 3)
                begin
                    z = 0;
                    trk_ref = trk_ref - PHASE_W'(full);
                end
                else if (z < 0)
                begin
                    z = 3;
                    trk_ref = trk_ref + PHASE_W'(full);
                end
                trk_zone = ZONE_W'(z);
            end
            ph = zone_phase_of(trk_zone, trk_zone[0] ? det_b : det_a);
            ph_s = ph;
            ref_s = trk_ref;
            sum = int'(trk_accum) + int'(ph_s) - int'(ref_s);
            // Hold the accumulator when the sum would not stay positive
            if (sum > 0)
                trk_accum = PHASE_W'(sum);
            trk_ref = ph;
        end
        res.dac_code = trk_accum[15:4];
        res.zone_now = trk_zone;
        res.phase_now = ph;
        pending_results.push_back(res);
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [LEVEL_W-1:0] pick_level(input level_kind_t kind);
        case (kind)
            LVL_HIGH:
                if (cf_upper < LEVEL_MAX)
                    return LEVEL_W'($urandom_range(LEVEL_MAX, int'(cf_upper) + 1));
            LVL_LOW:
                if (cf_lower > 0)
                    return LEVEL_W'($urandom_range(int'(cf_lower) - 1, 0));
            default:
                if (cf_lower <= cf_upper)
                    return LEVEL_W'($urandom_range(int'(cf_upper), int'(cf_lower)));
        endcase
        // Thresholds leave no room for that level: fall back to any value
        return LEVEL_W'($urandom_range(LEVEL_MAX, 0));
    endfunction

    // Build a pair that steps the tracked zone the way asked for.
    function automatic void guided_pair(input step_kind_t kind,
                                        output logic [LEVEL_W-1:0] det_a,
                                        output logic [LEVEL_W-1:0] det_b);
        logic rising;
        logic [LEVEL_W-1:0] act;
        logic [LEVEL_W-1:0] other;
        rising = (trk_zone < 2);
        case (kind)
            STEP_FWD: act = pick_level(rising ? LVL_HIGH : LVL_LOW);
            STEP_BACK: act = pick_level(rising ? LVL_LOW : LVL_HIGH);
            STEP_HOLD: act = pick_level(LVL_MID);
            default: act = LEVEL_W'($urandom_range(LEVEL_MAX, 0));
        endcase
        other = LEVEL_W'($urandom_range(LEVEL_MAX, 0));
        if (trk_zone[0])
        begin
            det_a = other;
            det_b = act;
        end
        else
        begin
            det_a = act;
            det_b = other;
        end
    endfunction

    // Offer one pair; return at the falling edge after its transaction,
    // with tvalid still high so that a back-to-back pair keeps it there.
    task automatic send_pair(input logic [LEVEL_W-1:0] det_a, input logic [LEVEL_W-1:0] det_b);
        int gap;
        gap = $urandom_range(tx_max_gap, 0);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata <= {det_b, det_a};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        unwrap_predict(det_a, det_b);
        pairs_sent++;
        @(negedge clk);
    endtask

    // Drop the input and wait until every queued result has come back.
    task automatic settle_pipeline();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Write all four registers back to back once the block is idle.
    task automatic program_regs(input logic [SCALE_W-1:0] scale,
                                input logic [LEVEL_W-1:0] upper,
                                input logic [LEVEL_W-1:0] lower,
                                input logic [LEVEL_W-1:0] center);
        logic [CFG_IDX_W-1:0] idx [4];
        logic [CFG_DATA_W-1:0] val [4];
        idx = '{REG_SCALE_SELECT, REG_UPPER_THRESHOLD, REG_LOWER_THRESHOLD, REG_CENTER_LEVEL};
        val = '{CFG_DATA_W'(scale), upper, lower, center};
        settle_pipeline();
        for (int i = 0; i < 4; i++)
        begin
            cfg_index <= idx[i];
            cfg_data <= val[i];
            cfg_valid <= 1'b1;
            do
                @(posedge clk);
            while (!cfg_ready);
            case (idx[i])
                REG_SCALE_SELECT: cf_scale = val[i][SCALE_W-1:0];
                REG_UPPER_THRESHOLD: cf_upper = val[i];
                REG_LOWER_THRESHOLD: cf_lower = val[i];
                REG_CENTER_LEVEL: cf_center = val[i];
                default: ;
            endcase
            reg_writes++;
            @(negedge clk);
        end
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Sometimes run a phase with no idling on one side or both.
    task automatic pick_idle_profile();
        tx_max_gap = ($urandom_range(3, 0) == 0) ? 0 : 8;
        rx_max_stall = ($urandom_range(3, 0) == 0) ? 0 : 8;
    endtask

    // Random pairs in runs of zone steps; about one in seven is pure noise.
    task automatic run_random_burst(input int count);
        step_kind_t kind;
        int run_left;
        int pick;
        logic [LEVEL_W-1:0] det_a;
        logic [LEVEL_W-1:0] det_b;
        run_left = 0;
        kind = STEP_HOLD;
        for (int i = 0; i < count; i++)
        begin
            if (run_left == 0)
            begin
                pick = $urandom_range(99, 0);
                if (pick < 35)
                    kind = STEP_FWD;
                else if (pick < 60)
                    kind = STEP_BACK;
                else if (pick < 85)
                    kind = STEP_HOLD;
                else
                    kind = STEP_NOISE;
                run_left = $urandom_range(6, 1);
            end
            run_left--;
            guided_pair(kind, det_a, det_b);
            send_pair(det_a, det_b);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_first_pair();
        // a above b with b under the lower threshold: start in zone 0
        send_pair(12'd3000, 12'd100);
    endtask

    task automatic test_field_extremes();
        send_pair(12'd0, 12'd0);
        send_pair(12'hFFF, 12'hFFF);
        send_pair(12'hFFF, 12'd0);
        send_pair(12'd0, 12'hFFF);
        send_pair(12'hAAA, 12'h555);
        send_pair(12'h555, 12'hAAA);
        send_pair(12'd2048, 12'd2048);
    endtask

    task automatic test_zone_wrap();
        logic [LEVEL_W-1:0] det_a;
        logic [LEVEL_W-1:0] det_b;
        // Six steps up pass 3 -> 0, six steps down pass 0 -> 3
        repeat (6)
        begin
            guided_pair(STEP_FWD, det_a, det_b);
            send_pair(det_a, det_b);
        end
        repeat (6)
        begin
            guided_pair(STEP_BACK, det_a, det_b);
            send_pair(det_a, det_b);
        end
    endtask

    task automatic test_scale_sweep();
        // Codes 6 and 7 must behave as 5
        for (int s = 0; s < 8; s++)
        begin
            program_regs(SCALE_W'(s), RST_UPPER, RST_LOWER, RST_CENTER);
            pick_idle_profile();
            run_random_burst(40);
        end
    endtask

    task automatic test_threshold_extremes();
        // Zone frozen, zone moving every pair, center at both ends
        program_regs(SCALE_W'($urandom_range(7, 0)), 12'hFFF, 12'd0, RST_CENTER);
        run_random_burst(40);
        program_regs(SCALE_W'($urandom_range(7, 0)), 12'd0, 12'hFFF, RST_CENTER);
        run_random_burst(40);
        program_regs(SCALE_W'($urandom_range(7, 0)), RST_UPPER, RST_LOWER, 12'd0);
        run_random_burst(40);
        program_regs(SCALE_W'($urandom_range(7, 0)), RST_UPPER, RST_LOWER, 12'hFFF);
        run_random_burst(40);
    endtask

    task automatic test_random_settings();
        logic [LEVEL_W-1:0] upper;
        logic [LEVEL_W-1:0] lower;
        logic [LEVEL_W-1:0] center;
        repeat (12)
        begin
            upper = LEVEL_W'($urandom_range(4000, 1200));
            lower = LEVEL_W'($urandom_range(1100, 50));
            center = $urandom_range(1, 0) ? LEVEL_W'($urandom_range(LEVEL_MAX, 0))
                                          : LEVEL_W'($urandom_range(1600, 800));
            program_regs(SCALE_W'($urandom_range(7, 0)), upper, lower, center);
            pick_idle_profile();
            run_random_burst(60);
        end
    endtask

    task automatic test_output_backpressure();
        program_regs(RST_SCALE, RST_UPPER, RST_LOWER, RST_CENTER);
        tx_max_gap = 0;
        rx_max_stall = 8;
        // Receiver holds off after its next transaction; keep offering pairs
        rx_hold_cycles = 80;
        run_random_burst(48);
    endtask

    // ------------------------------------------------------------------------
    // Result receiver and checker
    // ------------------------------------------------------------------------
    task automatic check_result(input logic [31:0] data);
        unwrap_result_t want;
        if (pending_results.size() == 0)
        begin
            $error("unexpected result transaction: tdata %h", data);
            mismatch_count++;
            return;
        end
        want = pending_results.pop_front();
        results_checked++;
        if (data[11:0] !== want.dac_code)
        begin
            $error("dac_code: expected %0d, actual %0d", want.dac_code, data[11:0]);
            mismatch_count++;
        end
        if (data[13:12] !== want.zone_now)
        begin
            $error("zone_now: expected %0d, actual %0d", want.zone_now, data[13:12]);
            mismatch_count++;
        end
        if (data[29:14] !== want.phase_now)
        begin
            $error("phase_now: expected %0d, actual %0d",
                   $signed(want.phase_now), $signed(data[29:14]));
            mismatch_count++;
        end
    endtask

    initial
    begin : result_receiver
        int stall;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            // Long hold-off, counted here, so the pipeline backs up
            if (rx_hold_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (rx_hold_cycles) @(negedge clk);
                rx_hold_cycles = 0;
            end
            stall = $urandom_range(rx_max_stall, 0);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            check_result(m_axis_tdata);
            @(negedge clk);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run when no transaction moves for too long
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= STALL_LIMIT)
        begin
            $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        s_axis_tdata = '0;
        s_axis_tvalid = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_first_pair();
        test_field_extremes();
        test_zone_wrap();
        test_scale_sweep();
        test_threshold_extremes();
        test_random_settings();
        test_output_backpressure();

        // Let the last results drain, then wait on for any stray result
        settle_pipeline();
        repeat (PIPE_LATENCY + 5) @(posedge clk);

        $display("Run covered %0d sample pairs and %0d results over %0d register settings",
                 pairs_sent, results_checked, settings_used);
        $display("(%0d register writes: every scale code, threshold and center extremes).",
                 reg_writes);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
